// ===== rtl/rmr_pkg.sv =====
// ----------------------------------------------------------------------------
// rmr_pkg: shared types and constants for the rational multiply/reduce core
// Field widths of the channel payloads and status bundles between units.
// ----------------------------------------------------------------------------
package rmr_pkg;

  // Width of each operand field on the input channel.
  localparam int FIELD_W = 32;
  // Width of each result field on the output channel.
  localparam int PROD_W  = 64;

  // Status from the GCD unit back to the sequencer.
  typedef struct packed {
    logic done;  // y reached zero, g/num_s/den_s are final
    logic zero;  // gcd is zero (both products were zero)
  } gcd_stat_t;

endpackage

// ===== rtl/rmr_if.sv =====
// ----------------------------------------------------------------------------
// rmr_if: valid/ready channels of the rational multiply/reduce core
// Operand channel carries two fractions, result channel one reduced fraction.
// ----------------------------------------------------------------------------
interface rmr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmr_pkg::FIELD_W-1:0] a_num;
  logic signed [rmr_pkg::FIELD_W-1:0] a_den;
  logic signed [rmr_pkg::FIELD_W-1:0] b_num;
  logic signed [rmr_pkg::FIELD_W-1:0] b_den;

  modport source (output valid, output a_num, output a_den, output b_num,
                  output b_den, input ready);
  modport sink   (input valid, input a_num, input a_den, input b_num,
                  input b_den, output ready);
endinterface

interface rmr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmr_pkg::PROD_W-1:0] prod_num;
  logic signed [rmr_pkg::PROD_W-1:0] prod_den;

  modport source (output valid, output prod_num, output prod_den, input ready);
  modport sink   (input valid, input prod_num, input prod_den, output ready);
endinterface

// ===== rtl/rmr_mul.sv =====
// ----------------------------------------------------------------------------
// rmr_mul: shared signed multiplier with registered product
// One W x W signed multiply per enabled cycle, full 2W-bit result.
// ----------------------------------------------------------------------------
module rmr_mul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] prod
);

  // Both operands signed: extended to 2W before the multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== rtl/rmr_gcd.sv =====
// ----------------------------------------------------------------------------
// rmr_gcd: binary GCD unit, one compare/subtract or shift per cycle
// Returns the odd part of the gcd (all of it if an input is zero) and both
// inputs with the common power of two removed, so the quotients need no shift afterwards.
// ----------------------------------------------------------------------------
module rmr_gcd #(
  parameter int MW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MW-1:0]      x_in,
  input  logic [MW-1:0]      y_in,
  output logic [MW-1:0]      g,
  output logic [MW-1:0]      num_s,
  output logic [MW-1:0]      den_s,
  output rmr_pkg::gcd_stat_t stat
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t        state;
  logic [MW-1:0] x;
  logic [MW-1:0] y;
  logic [MW-1:0] sn;
  logic [MW-1:0] sd;
  logic [MW:0]   diff;

  // y - x; top bit set means x > y
  assign diff = {1'b0, y} - {1'b0, x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x     <= x_in;
            y     <= y_in;
            sn    <= x_in;
            sd    <= y_in;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (y == '0) begin
            state <= S_IDLE;
          end else if (x == '0) begin
            // gcd(0, y) = y
            x <= y;
            y <= '0;
          end else if (!x[0] && !y[0]) begin
            // common factor of two: strip it from the dividends too
            x  <= x >> 1;
            y  <= y >> 1;
            sn <= sn >> 1;
            sd <= sd >> 1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (diff[MW]) begin
            x <= y;
            y <= x;
          end else begin
            y <= diff[MW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign g         = x;
  assign num_s     = sn;
  assign den_s     = sd;
  assign stat.done = (state == S_RUN) && (y == '0);
  assign stat.zero = (x == '0);

endmodule

// ===== rtl/rmr_div.sv =====
// ----------------------------------------------------------------------------
// rmr_div: restoring unsigned divider, one quotient bit per cycle
// done pulses when quot is valid.
// ----------------------------------------------------------------------------
module rmr_div #(
  parameter int MW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] dividend,
  input  logic [MW-1:0] divisor,
  output logic [MW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(MW);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t        state;
  logic [MW-1:0] rem;
  logic [MW-1:0] q;
  logic [MW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [MW:0]   trial;

  // rem < dvs, so the top bit of trial is the borrow
  assign trial = {rem, q[MW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      // high for one cycle after the last quotient bit
      done <= (state == S_RUN) && (cnt == CW'(MW - 1));
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rem   <= '0;
            q     <= dividend;
            dvs   <= divisor;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!trial[MW]) begin
            rem <= trial[MW-1:0];
            q   <= {q[MW-2:0], 1'b1};
          end else begin
            rem <= {rem[MW-2:0], q[MW-1]};
            q   <= {q[MW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MW - 1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign quot = q;

endmodule

// ===== rtl/rational_multiply_reduce_core.sv =====
// ----------------------------------------------------------------------------
// rational_multiply_reduce_core: exact fraction multiply with gcd reduction
// The binary GCD loop is value dependent; 0/0 skips both divisions.
// Throughput: one item in flight, next operand transfer in the cycle after the
// result is loaded; the GCD loop and the bit-serial divider set the rate.
// Reset (rst, synchronous): sequencer idle, result channel empty.
// ----------------------------------------------------------------------------
//
// Flow of one item:
//   IDLE   : operand transfer, low OPERAND_WIDTH bits of each field latched
//   MUL_N  : shared multiplier forms a_num*b_num
//   MUL_D  : a_den*b_den; numerator product sign and magnitude saved
//   MAG    : denominator sign/magnitude; GCD unit started on both magnitudes
//   GCD    : binary GCD runs; zero gcd (0/0) skips the divisions
//   DIV_N  : numerator magnitude divided by the odd gcd part
//   DIV_D  : denominator magnitude divided by the same
//   FINISH : signs restored, result loaded into the output register
//
// The GCD unit removes the common power of two from both magnitudes as it
// goes, so with both magnitudes nonzero the divider divides by the odd part of the gcd.
// Signs are reapplied as computed: a negative denominator stays negative.
// The output register lets a finished result wait for the sink while the
// sequencer returns to IDLE and takes the next operand transfer.
module rational_multiply_reduce_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  rmr_in_if.sink    operands,
  rmr_out_if.source result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;     // product / magnitude width
  localparam int RW = rmr_pkg::PROD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_N, S_MUL_D, S_MAG, S_GCD, S_DIV_N, S_DIV_D, S_FINISH
  } state_t;

  state_t state;

  // latched operands, signed low W bits of each field
  logic signed [W-1:0] op_an;
  logic signed [W-1:0] op_ad;
  logic signed [W-1:0] op_bn;
  logic signed [W-1:0] op_bd;

  // shared multiplier
  logic signed [W-1:0]  mul_a;
  logic signed [W-1:0]  mul_b;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        prod_mag;

  // product signs and magnitudes
  logic          neg_n;
  logic          neg_d;
  logic [PW-1:0] mag_n;

  // GCD unit
  logic               gcd_start;
  logic [PW-1:0]      gcd_g;
  logic [PW-1:0]      gcd_num;
  logic [PW-1:0]      gcd_den;
  rmr_pkg::gcd_stat_t gcd_stat;

  // divider
  logic          div_start;
  logic [PW-1:0] div_dividend;
  logic [PW-1:0] div_quot;
  logic          div_done;

  // reduced magnitudes
  logic [PW-1:0] qn;
  logic [PW-1:0] qd;

  // output register
  logic          out_valid;
  logic [RW-1:0] res_num;
  logic [RW-1:0] res_den;
  logic [RW-1:0] ext_n;
  logic [RW-1:0] ext_d;
  logic          out_free;

  // --------------------------------------------------------------------------
  // Shared multiplier: numerator pair first, denominator pair next cycle
  // --------------------------------------------------------------------------
  assign mul_a = (state == S_MUL_N) ? op_an : op_ad;
  assign mul_b = (state == S_MUL_N) ? op_bn : op_bd;

  rmr_mul #(.W(W)) u_mul (
    .clk  (clk),
    .en   (state == S_MUL_N || state == S_MUL_D),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // |product| <= 2^(PW-2), so the negation never overflows
  assign prod_mag = prod[PW-1] ? (PW'(0) - $unsigned(prod)) : $unsigned(prod);

  // --------------------------------------------------------------------------
  // GCD unit, started once both magnitudes are known
  // --------------------------------------------------------------------------
  assign gcd_start = (state == S_MAG);

  rmr_gcd #(.MW(PW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .x_in  (mag_n),
    .y_in  (prod_mag),
    .g     (gcd_g),
    .num_s (gcd_num),
    .den_s (gcd_den),
    .stat  (gcd_stat)
  );

  // --------------------------------------------------------------------------
  // Divider: numerator when the GCD finishes, denominator right after
  // --------------------------------------------------------------------------
  assign div_start = ((state == S_GCD) && gcd_stat.done && !gcd_stat.zero) ||
                     ((state == S_DIV_N) && div_done);
  assign div_dividend = (state == S_GCD) ? gcd_num : gcd_den;

  rmr_div #(.MW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .quot     (div_quot),
    .done     (div_done)
  );

  // --------------------------------------------------------------------------
  // Sign restore and output register
  // --------------------------------------------------------------------------
  assign ext_n    = RW'(qn);
  assign ext_d    = RW'(qd);
  assign out_free = !out_valid || result.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load wins over the drain of the previous result
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (operands.valid) begin
            op_an <= operands.a_num[W-1:0];
            op_ad <= operands.a_den[W-1:0];
            op_bn <= operands.b_num[W-1:0];
            op_bd <= operands.b_den[W-1:0];
            state <= S_MUL_N;
          end
        end
        S_MUL_N: state <= S_MUL_D;
        S_MUL_D: begin
          neg_n <= prod[PW-1];
          mag_n <= prod_mag;
          state <= S_MAG;
        end
        S_MAG: begin
          neg_d <= prod[PW-1];
          state <= S_GCD;
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            if (gcd_stat.zero) begin
              // 0/0: nothing to reduce
              qn    <= '0;
              qd    <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_DIV_N;
            end
          end
        end
        S_DIV_N: begin
          if (div_done) begin
            qn    <= div_quot;
            state <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            qd    <= div_quot;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res_num   <= neg_n ? (RW'(0) - ext_n) : ext_n;
            res_den   <= neg_d ? (RW'(0) - ext_d) : ext_d;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign operands.ready  = (state == S_IDLE);
  assign result.valid    = out_valid;
  assign result.prod_num = res_num;
  assign result.prod_den = res_den;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rational_multiply_reduce_core
// Drives fraction pairs over the operand channel. A scoreboard predicts each
// reduced product and compares it with the result channel, field by field.
// The run has three idle profiles on the two sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FIELD_W = rmr_pkg::FIELD_W;
  localparam int PROD_W  = rmr_pkg::PROD_W;

  // Operand width that the core is built with; the predictor uses the same.
  localparam int OPW = 32;

  localparam logic [FIELD_W-1:0] S_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] S_ONE = 32'h0000_0001;
  localparam logic [FIELD_W-1:0] S_NEG = 32'hffff_ffff;

  // Cycles to let pass after every owed result has come back, before the final check.
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic signed [PROD_W-1:0] num;
    logic signed [PROD_W-1:0] den;
  } frac_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the reduced products still owed by the core, oldest
  // first. Each operand transfer pushes one; each result transfer pops one.
  // --------------------------------------------------------------------------
  class frac_scoreboard;
    frac_t owed_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    // Low OPW bits, sign-extended to the product width.
    function logic signed [PROD_W-1:0] widen(logic [FIELD_W-1:0] raw);
      logic signed [OPW-1:0] v;
      v = raw[OPW-1:0];
      return PROD_W'(v);
    endfunction

    function logic [PROD_W-1:0] mag(logic signed [PROD_W-1:0] v);
      return v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    endfunction

    // Exact product of both fractions, divided by gcd(|num|, |den|) unless
    // that gcd is zero. Signs follow the unreduced products.
    function frac_t reduce_product(logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
                                   logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
      logic signed [PROD_W-1:0] pn;
      logic signed [PROD_W-1:0] pd;
      logic [PROD_W-1:0]        mn;
      logic [PROD_W-1:0]        md;
      logic [PROD_W-1:0]        x;
      logic [PROD_W-1:0]        y;
      logic [PROD_W-1:0]        t;
      frac_t                    r;
      pn = widen(an) * widen(bn);
      pd = widen(ad) * widen(bd);
      mn = mag(pn);
      md = mag(pd);
      x  = mn;
      y  = md;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x != 0) begin
        mn = mn / x;
        md = md / x;
      end
      r.num = pn[PROD_W-1] ? -$signed(mn) : $signed(mn);
      r.den = pd[PROD_W-1] ? -$signed(md) : $signed(md);
      return r;
    endfunction

    function void note_operands(logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
                                logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
      owed_q.push_back(reduce_product(an, ad, bn, bd));
    endfunction

    function void check_product(logic signed [PROD_W-1:0] num,
                                logic signed [PROD_W-1:0] den);
      frac_t exp_f;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, num, den);
        errors++;
        return;
      end
      exp_f = owed_q.pop_front();
      if (num !== exp_f.num) begin
        $display("%0t: prod_num expected %0d actual %0d", $time, exp_f.num, num);
        errors++;
      end
      if (den !== exp_f.den) begin
        $display("%0t: prod_den expected %0d actual %0d", $time, exp_f.den, den);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rmr_in_if  operands_ch ();
  rmr_out_if result_ch ();

  rational_multiply_reduce_core #(
    .OPERAND_WIDTH(OPW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .result   (result_ch)
  );

  frac_scoreboard sb = new();

  // Idle rates in percent of cycles; changed between phases.
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sink side: ready is redrawn every falling edge.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: everything is sampled at the rising edge, inputs only move at
  // the falling edge. The result is checked before the new operands are
  // noted, since a transfer on the same edge always belongs to older work.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_product(result_ch.prod_num, result_ch.prod_den);
      if (operands_ch.valid && operands_ch.ready)
        sb.note_operands(operands_ch.a_num, operands_ch.a_den,
                         operands_ch.b_num, operands_ch.b_den);
    end
  end

  // One operand transfer. Entered and left just after a falling edge. Valid
  // stays high from one transfer into the next unless an idle cycle is drawn,
  // so it is never lowered and raised in the same step.
  task automatic send_item(logic [FIELD_W-1:0] an, logic [FIELD_W-1:0] ad,
                           logic [FIELD_W-1:0] bn, logic [FIELD_W-1:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      operands_ch.valid <= 1'b0;
      @(negedge clk);
    end
    operands_ch.valid <= 1'b1;
    operands_ch.a_num <= an;
    operands_ch.a_den <= ad;
    operands_ch.b_num <= bn;
    operands_ch.b_den <= bd;
    @(posedge clk);
    while (!operands_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the operand side until every owed result has come back.
  task automatic wait_drained();
    operands_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly small or structured values, so that real gcd reduction happens;
  // full-width noise flips every bit, plus zeros, powers of two, extremes.
  function automatic logic [FIELD_W-1:0] rand_operand();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom();
    if (sel < 55) begin
      v = int'($urandom_range(128)) - 64;
      return v;
    end
    if (sel < 70) begin
      v = int'($urandom_range(65534)) - 32767;
      return v * int'($urandom_range(1, 9));
    end
    if (sel < 80) begin
      v = 1 << $urandom_range(31);
      return $urandom_range(1) ? -v : v;
    end
    if (sel < 86) return '0;
    if (sel < 94) begin
      case ($urandom_range(3))
        0: return S_MAX;
        1: return S_MIN;
        2: return S_ONE;
        default: return S_NEG;
      endcase
    end
    return $urandom() << $urandom_range(24);
  endfunction

  function automatic int rand_small();
    return int'($urandom_range(65534)) - 32767;
  endfunction

  // Random part: independent operands, pairs built around a shared factor,
  // and integer multipliers or single-fraction reductions.
  task automatic run_random(int count);
    int               mode;
    int               f;
    logic [FIELD_W-1:0] an, ad, bn, bd;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(99);
      if (mode < 40) begin
        an = rand_operand();
        ad = rand_operand();
        bn = rand_operand();
        bd = rand_operand();
      end else if (mode < 80) begin
        // common factor lands in both products; |f*m| stays below 2^31
        f  = $urandom_range(1) ? (1 << $urandom_range(15)) : int'($urandom_range(1, 65535));
        an = f * rand_small();
        bn = rand_small();
        if ($urandom_range(1)) begin
          ad = f * rand_small();
          bd = rand_small();
        end else begin
          ad = rand_small();
          bd = f * rand_small();
        end
      end else if (mode < 90) begin
        an = rand_operand();
        ad = rand_operand();
        bn = rand_operand();
        bd = S_ONE;
      end else begin
        an = rand_operand();
        ad = rand_operand();
        bn = S_ONE;
        bd = S_ONE;
      end
      send_item(an, ad, bn, bd);
    end
  endtask

  // Edge cases first: 0/0, zero numerator with either denominator sign,
  // zero denominator with either numerator sign, full-scale operands,
  // integer multiply and reduction of a lone fraction.
  task automatic run_directed();
    send_item('0, '0, '0, '0);
    send_item('0, 32'd5, 32'd7, 32'd3);
    send_item('0, -32'sd5, 32'd7, 32'd3);
    send_item(32'd3, '0, 32'd5, 32'd7);
    send_item(-32'sd3, '0, 32'd5, 32'd7);
    send_item('0, '0, 32'd5, 32'd7);
    send_item(S_MIN, S_MIN, S_MIN, S_MIN);
    send_item(S_MAX, S_MAX, S_MAX, S_MAX);
    send_item(S_MIN, S_MAX, S_MAX, S_MIN);
    send_item(S_MAX, S_ONE, S_MIN, S_ONE);
    send_item(S_MIN, S_ONE, S_NEG, S_ONE);
    send_item(32'd6, 32'd8, S_ONE, S_ONE);
    send_item(32'd6, -32'sd8, S_ONE, S_ONE);
    send_item(S_NEG, S_NEG, S_NEG, S_NEG);
    send_item(S_ONE, S_ONE, S_ONE, S_ONE);
    send_item(32'd12, 32'd35, 32'd14, 32'd9);
    send_item(32'h4000_0000, 32'd3, 32'd3, 32'h4000_0000);
    send_item(32'd7, S_MIN, '0, S_ONE);
    send_item(32'd5, 32'd3, S_MIN, '0);
    send_item(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
    send_item(32'd1024, -32'sd4096, -32'sd3, 32'd12);
  endtask

  // Hard stop in case the core hangs.
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    send_idle_pct     = 20;
    recv_idle_pct     = 85;
    rst               = 1'b1;
    operands_ch.valid = 1'b0;
    operands_ch.a_num = '0;
    operands_ch.a_den = '0;
    operands_ch.b_num = '0;
    operands_ch.b_den = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // slow sink: results back up in the output register
    run_directed();
    run_random(290);
    wait_drained();

    // slow source: core mostly waits on operands
    send_idle_pct = 85;
    recv_idle_pct = 20;
    run_random(300);
    wait_drained();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(200);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
